>>> hdl/dk2_pkg.sv
package dk2_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W  = 32;
    localparam int WARM_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic [DATA_W-1:0] var_t;
    typedef logic [WARM_W-1:0] warm_cnt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_PROCESS_NOISE = 2'd0;
    localparam cfg_idx_t REG_MEASURE_NOISE = 2'd1;
    localparam cfg_idx_t REG_WARMUP_ITEMS  = 2'd2;

    // Reset values of the configuration registers.
    localparam var_t      PROCESS_NOISE_RST = 32'd655;
    localparam var_t      MEASURE_NOISE_RST = 32'd65536;
    localparam warm_cnt_t WARMUP_ITEMS_RST  = 16'd10;

    // Command from the sequencer to one axis lane.
    typedef struct packed {
        logic start;
        logic warm;
    } lane_ctrl_t;

    // Status from one axis lane back to the sequencer.
    typedef struct packed {
        logic done;
    } lane_stat_t;

endpackage

>>> hdl/dk2_in_if.sv
interface dk2_in_if;
    logic            valid;
    logic            ready;
    dk2_pkg::coord_t ctrl_x;
    dk2_pkg::coord_t ctrl_y;
    dk2_pkg::coord_t meas_x;
    dk2_pkg::coord_t meas_y;

    modport source (output valid, output ctrl_x, output ctrl_y, output meas_x,
                    output meas_y, input ready);
    modport sink (input valid, input ctrl_x, input ctrl_y, input meas_x,
                  input meas_y, output ready);
endinterface

>>> hdl/dk2_out_if.sv
interface dk2_out_if;
    logic            valid;
    logic            ready;
    dk2_pkg::coord_t est_x;
    dk2_pkg::coord_t est_y;
    dk2_pkg::coord_t pred_x;
    dk2_pkg::coord_t pred_y;
    logic            warming_up;

    modport source (output valid, output est_x, output est_y, output pred_x,
                    output pred_y, output warming_up, input ready);
    modport sink (input valid, input est_x, input est_y, input pred_x,
                  input pred_y, input warming_up, output ready);
endinterface

>>> hdl/dk2_axis.sv
module dk2_axis #(
    parameter int FRAC_BITS = dk2_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dk2_pkg::lane_ctrl_t ctrl,
    output dk2_pkg::lane_stat_t stat,
    input  dk2_pkg::coord_t     u,
    input  dk2_pkg::coord_t     z,
    input  dk2_pkg::var_t       q,
    input  dk2_pkg::var_t       r,
    output dk2_pkg::coord_t     pred,
    output dk2_pkg::coord_t     est
);

    localparam int G_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int PE_W  = 34 + G_W;
    localparam int SX_W  = PE_W + 1;
    localparam int PP_W  = 32 + G_W;
    localparam int NP_W  = PP_W + 1;

    localparam logic [G_W-1:0]  ONE    = G_W'(1) << FRAC_BITS;
    localparam logic [PE_W-1:0] HALF_E = PE_W'(1) << (FRAC_BITS - 1);
    localparam logic [NP_W-1:0] HALF_P = NP_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [6:0] {
        L_IDLE = 7'b0000001,
        L_PREP = 7'b0000010,
        L_DIV  = 7'b0000100,
        L_MULE = 7'b0001000,
        L_MULP = 7'b0010000,
        L_FIN  = 7'b0100000,
        L_DONE = 7'b1000000
    } lane_state_t;

    lane_state_t state_reg, state_next;

    dk2_pkg::coord_t est_reg, est_next;
    dk2_pkg::var_t   var_reg, var_next;
    dk2_pkg::coord_t pred_reg, pred_next;
    dk2_pkg::coord_t z_reg, z_next;
    dk2_pkg::var_t   pp_reg, pp_next;
    logic [32:0]     den_reg, den_next;
    logic [33:0]     rem_reg, rem_next;
    logic [G_W-1:0]  quo_reg, quo_next;
    logic [G_W-1:0]  gain_reg, gain_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [32:0] err_reg, err_next;
    logic signed [PE_W-1:0] prod_e_reg, prod_e_next;
    logic [PP_W-1:0] prod_p_reg, prod_p_next;

    logic signed [32:0] pred_sum;
    logic [32:0]        pp_sum;
    logic [33:0]        shifted;
    logic               ge;
    logic [G_W-1:0]     gain_sel;
    logic signed [PE_W-1:0] corr;
    logic signed [SX_W-1:0] est_sum;
    logic [NP_W-1:0]    np_full;
    logic [NP_W-1:0]    np_shift;

    always_comb
    begin
        pred_sum = {est_reg[31], est_reg} + {u[31], u};
        pp_sum   = {1'b0, var_reg} + {1'b0, q};
        shifted  = (cnt_reg == '0) ? rem_reg : {rem_reg[32:0], 1'b0};
        ge       = shifted >= {1'b0, den_reg};
        gain_sel = (den_reg == '0) ? '0 : quo_reg;
        corr     = (prod_e_reg + $signed(HALF_E)) >>> FRAC_BITS;
        est_sum  = {corr[PE_W-1], corr} + SX_W'(pred_reg);
        np_full  = {1'b0, prod_p_reg} + HALF_P;
        np_shift = np_full >> FRAC_BITS;
    end

    always_comb
    begin
        state_next  = state_reg;
        est_next    = est_reg;
        var_next    = var_reg;
        pred_next   = pred_reg;
        z_next      = z_reg;
        pp_next     = pp_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        gain_next   = gain_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        prod_e_next = prod_e_reg;
        prod_p_next = prod_p_reg;
        unique case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (ctrl.start)
                begin
                    if (ctrl.warm)
                    begin
                        est_next   = z;
                        pred_next  = z;
                        state_next = L_DONE;
                    end
                    else
                    begin
                        // Saturating predict of estimate and variance.
                        if (pred_sum[32] != pred_sum[31])
                        begin
                            pred_next = pred_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
                        end
                        else
                        begin
                            pred_next = pred_sum[31:0];
                        end
                        pp_next    = pp_sum[32] ? '1 : pp_sum[31:0];
                        z_next     = z;
                        state_next = L_PREP;
                    end
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            L_PREP:
            begin
                den_next   = {1'b0, pp_reg} + {1'b0, r};
                rem_next   = {2'b00, pp_reg};
                quo_next   = '0;
                cnt_next   = '0;
                err_next   = {z_reg[31], z_reg} - {pred_reg[31], pred_reg};
                state_next = L_DIV;
            end
            L_DIV:
            begin
                // One restoring step per cycle; the first step has no shift.
                rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
                quo_next = {quo_reg[G_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    state_next = L_MULE;
                end
            end
            L_MULE:
            begin
                gain_next   = gain_sel;
                prod_e_next = PE_W'(err_reg) * PE_W'($signed({1'b0, gain_sel}));
                state_next  = L_MULP;
            end
            L_MULP:
            begin
                prod_p_next = PP_W'(ONE - gain_reg) * PP_W'(pp_reg);
                if (est_sum[SX_W-1:31] != '0 && est_sum[SX_W-1:31] != '1)
                begin
                    est_next = est_sum[SX_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
                end
                else
                begin
                    est_next = est_sum[31:0];
                end
                state_next = L_FIN;
            end
            L_FIN:
            begin
                var_next   = (np_shift > NP_W'(pp_reg)) ? pp_reg : np_shift[31:0];
                state_next = L_DONE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            est_reg   <= '0;
            var_reg   <= dk2_pkg::var_t'(1) << FRAC_BITS;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            est_reg   <= est_next;
            var_reg   <= var_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pred_reg   <= pred_next;
        z_reg      <= z_next;
        pp_reg     <= pp_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        gain_reg   <= gain_next;
        err_reg    <= err_next;
        prod_e_reg <= prod_e_next;
        prod_p_reg <= prod_p_next;
    end

    assign stat.done = (state_reg == L_DONE);
    assign pred      = pred_reg;
    assign est       = est_reg;

endmodule

>>> hdl/diagonal_kalman_2d_tracker_top.sv
// Two-axis position tracker built from two independent scalar Kalman filters, one lane
// per axis, running side by side on the same item. Each item carries a control offset
// and a measured position per axis, and yields one result item with the estimate, the
// prediction and a warm-up flag. For the first warmup_items items the estimate is just
// loaded with the measurement. After that each lane predicts, forms the gain with a
// bit-serial restoring divider that produces one quotient bit per cycle, and corrects
// the estimate and variance through two registered multiplies; a new item is accepted
// only once both lanes have finished and their result is in the output register. The
// result sits in an output register, so a stalled consumer does not hold up the lanes
// until the next result is finished. Configuration registers are written through a
// plain write port; the user must write them only while the block is idle, as the
// block itself does not enforce it.
module diagonal_kalman_2d_tracker_top #(
    parameter int FRAC_BITS = dk2_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    dk2_in_if.sink            sample,
    dk2_out_if.source         result,
    input  logic              cfg_wr_en,
    input  dk2_pkg::cfg_idx_t cfg_index,
    input  dk2_pkg::var_t     cfg_data
);

    // The sequencer is either waiting for an item or waiting for both lanes and the output register.
    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_RUN  = 2'b10
    } top_state_t;

    top_state_t state_reg, state_next;

    // Configuration registers.
    dk2_pkg::var_t      process_noise_reg;
    dk2_pkg::var_t      measure_noise_reg;
    dk2_pkg::warm_cnt_t warmup_items_reg;

    // Number of warm-up items consumed so far; it stops once warm-up is over.
    dk2_pkg::warm_cnt_t warmup_seen_reg, warmup_seen_next;
    logic               warm_reg, warm_next;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    dk2_pkg::coord_t est_x_reg, est_y_reg, pred_x_reg, pred_y_reg;
    logic            warming_up_reg;

    dk2_pkg::lane_ctrl_t lane_ctrl;
    dk2_pkg::lane_stat_t lane_x_stat, lane_y_stat;
    dk2_pkg::coord_t     lane_x_pred, lane_y_pred, lane_x_est, lane_y_est;

    logic accept;
    logic warm_now;
    logic lanes_done;
    logic load_out;

    assign sample.ready = (state_reg == T_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign warm_now     = warmup_seen_reg < warmup_items_reg;

    // Both lanes receive the same command and so run in lockstep.
    assign lane_ctrl.start = accept;
    assign lane_ctrl.warm  = warm_now;

    dk2_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .stat  (lane_x_stat),
        .u     (sample.ctrl_x),
        .z     (sample.meas_x),
        .q     (process_noise_reg),
        .r     (measure_noise_reg),
        .pred  (lane_x_pred),
        .est   (lane_x_est)
    );

    dk2_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .stat  (lane_y_stat),
        .u     (sample.ctrl_y),
        .z     (sample.meas_y),
        .q     (process_noise_reg),
        .r     (measure_noise_reg),
        .pred  (lane_y_pred),
        .est   (lane_y_est)
    );

    // The merge stage collects both lanes into the output register once the
    // previous result has left or is leaving in this cycle.
    assign lanes_done = lane_x_stat.done && lane_y_stat.done;
    assign load_out   = (state_reg == T_RUN) && lanes_done && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next       = state_reg;
        warmup_seen_next = warmup_seen_reg;
        warm_next        = warm_reg;
        out_valid_next   = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    warm_next  = warm_now;
                    state_next = T_RUN;
                    if (warm_now)
                    begin
                        warmup_seen_next = warmup_seen_reg + dk2_pkg::warm_cnt_t'(1);
                    end
                end
            end
            T_RUN:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            warmup_seen_reg   <= '0;
            warm_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            process_noise_reg <= dk2_pkg::PROCESS_NOISE_RST;
            measure_noise_reg <= dk2_pkg::MEASURE_NOISE_RST;
            warmup_items_reg  <= dk2_pkg::WARMUP_ITEMS_RST;
        end
        else
        begin
            state_reg       <= state_next;
            warmup_seen_reg <= warmup_seen_next;
            warm_reg        <= warm_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    dk2_pkg::REG_PROCESS_NOISE: process_noise_reg <= cfg_data;
                    dk2_pkg::REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    dk2_pkg::REG_WARMUP_ITEMS:
                        warmup_items_reg <= cfg_data[dk2_pkg::WARM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            est_x_reg      <= lane_x_est;
            est_y_reg      <= lane_y_est;
            pred_x_reg     <= lane_x_pred;
            pred_y_reg     <= lane_y_pred;
            warming_up_reg <= warm_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.est_x      = est_x_reg;
    assign result.est_y      = est_y_reg;
    assign result.pred_x     = pred_x_reg;
    assign result.pred_y     = pred_y_reg;
    assign result.warming_up = warming_up_reg;

    // The two lanes are started together and must always finish together.
    assert property (@(posedge clk) disable iff (!rst_n)
        lane_x_stat.done == lane_y_stat.done)
    else $error("axis lanes lost lockstep");

    // A warm-up item advances the warm-up count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && warm_now |=> warmup_seen_reg == $past(warmup_seen_reg) + 16'd1)
    else $error("warm-up count did not advance");

    // A new result only appears after the sequencer waited on the lanes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_RUN && lanes_done))
    else $error("result loaded without finished lanes");

endmodule
